[design/mse_pkg.sv]
// Shared constants and controller/datapath command and status types for the merge sort engine.
package mse_pkg;

  localparam int unsigned MSE_MAX_ITEMS = 64;
  localparam int unsigned MSE_DATA_W    = 64;

  typedef struct packed {
    logic rd_sel;      // 0: read store A, 1: read store B
    logic wr_a;
    logic wr_b;
    logic wr_from_in;  // write the input value instead of a merge head
    logic take_left;
    logic ld_l;
    logic ld_r;
    logic out_load;
    logic out_last;
    logic out_ovf;
  } mse_cmd_t;

  typedef struct packed {
    logic le;          // left head <= right head, signed
    logic out_busy;    // output register holds an item not yet taken
  } mse_sts_t;

endpackage

[design/mse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/mse_dp.sv]
// Datapath: the two element stores, the merge head registers, the comparator and the output register.
module mse_dp
  import mse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MSE_MAX_ITEMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mse_cmd_t                     cmd,
  input  logic [$clog2(MAX_ITEMS)-1:0] rd_addr,
  input  logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
  output mse_sts_t                     sts,
  input  logic [MSE_DATA_W-1:0]        in_value,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [MSE_DATA_W-1:0]        out_tdata,
  output logic                         out_tlast,
  output logic                         out_tuser
);

  logic [MSE_DATA_W-1:0] rdata_a;
  logic [MSE_DATA_W-1:0] rdata_b;
  logic [MSE_DATA_W-1:0] rdata;
  logic [MSE_DATA_W-1:0] wdata;
  logic [MSE_DATA_W-1:0] hl_r, hl_nxt;
  logic [MSE_DATA_W-1:0] hr_r, hr_nxt;
  logic [MSE_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;

  assign wdata = cmd.wr_from_in ? in_value : (cmd.take_left ? hl_r : hr_r);
  assign rdata = cmd.rd_sel ? rdata_b : rdata_a;

  mse_ram #(
    .WIDTH (MSE_DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  mse_ram #(
    .WIDTH (MSE_DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  always_comb begin
    hl_nxt        = cmd.ld_l ? rdata : hl_r;
    hr_nxt        = cmd.ld_r ? rdata : hr_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (cmd.out_load) begin
      out_data_nxt  = rdata;
      out_last_nxt  = cmd.out_last;
      out_ovf_nxt   = cmd.out_ovf;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    hl_r       <= hl_nxt;
    hr_r       <= hr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign sts.le       = $signed(hl_r) <= $signed(hr_r);
  assign sts.out_busy = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

[design/mse_ctrl.sv]
// Controller: load counting, bottom-up merge pass sequencing and output sequencing.
module mse_ctrl
  import mse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MSE_MAX_ITEMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_tlast,
  input  logic                         out_tready,
  input  mse_sts_t                     sts,
  output mse_cmd_t                     cmd,
  output logic [$clog2(MAX_ITEMS)-1:0] rd_addr,
  output logic [$clog2(MAX_ITEMS)-1:0] wr_addr
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned SW = CW + 3;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_BLK   = 4'd1;
  localparam logic [3:0] S_FL    = 4'd2;
  localparam logic [3:0] S_FR    = 4'd3;
  localparam logic [3:0] S_MERGE = 4'd4;
  localparam logic [3:0] S_ML    = 4'd5;
  localparam logic [3:0] S_MR    = 4'd6;
  localparam logic [3:0] S_ORD   = 4'd7;
  localparam logic [3:0] S_OLD   = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] l_r, l_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] o_r, o_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          sel_r, sel_nxt;

  logic [SW-1:0] sum_mid;
  logic [SW-1:0] sum_hi;
  logic [CW-1:0] blk_mid;
  logic [CW-1:0] blk_hi;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] l_inc;
  logic [CW-1:0] r_inc;
  logic [CW-1:0] o_inc;
  logic [CW-1:0] k_inc;
  logic [WW-1:0] w_dbl;
  logic          in_xfer;
  logic          room;
  logic          take_left;

  assign in_xfer = in_tvalid && in_tready;
  assign in_tready = (state_r == S_LOAD);
  assign room = cnt_r < CW'(MAX_ITEMS);
  assign cnt_inc = cnt_r + 1'b1;
  assign l_inc = l_r + 1'b1;
  assign r_inc = r_r + 1'b1;
  assign o_inc = o_r + 1'b1;
  assign k_inc = k_r + 1'b1;
  assign w_dbl = w_r << 1;

  // Block bounds, clamped to the set size.
  assign sum_mid = SW'(lo_r) + SW'(w_r);
  assign sum_hi  = sum_mid + SW'(w_r);
  assign blk_mid = (sum_mid > SW'(cnt_r)) ? cnt_r : sum_mid[CW-1:0];
  assign blk_hi  = (sum_hi > SW'(cnt_r)) ? cnt_r : sum_hi[CW-1:0];

  // Ties go to the left run, which keeps the sort stable.
  assign take_left = (l_r < mid_r) && (!(r_r < hi_r) || sts.le);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    w_nxt     = w_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    o_nxt     = o_r;
    k_nxt     = k_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.rd_sel = sel_r;
    rd_addr   = lo_r[AW-1:0];
    wr_addr   = o_r[AW-1:0];

    case (state_r)
      S_LOAD: begin
        wr_addr = cnt_r[AW-1:0];
        if (in_xfer) begin
          if (room) begin
            cmd.wr_a       = 1'b1;
            cmd.wr_from_in = 1'b1;
            cnt_nxt        = cnt_inc;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            lo_nxt  = '0;
            w_nxt   = WW'(1);
            sel_nxt = 1'b0;
            k_nxt   = '0;
            if (cnt_nxt > CW'(1)) begin
              state_nxt = S_BLK;
            end else begin
              state_nxt = S_ORD;
            end
          end
        end
      end
      S_BLK: begin
        rd_addr   = lo_r[AW-1:0];
        l_nxt     = lo_r;
        r_nxt     = blk_mid;
        o_nxt     = lo_r;
        mid_nxt   = blk_mid;
        hi_nxt    = blk_hi;
        state_nxt = S_FL;
      end
      S_FL: begin
        cmd.ld_l = 1'b1;
        rd_addr  = mid_r[AW-1:0];
        if (mid_r < hi_r) begin
          state_nxt = S_FR;
        end else begin
          state_nxt = S_MERGE;
        end
      end
      S_FR: begin
        cmd.ld_r  = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.wr_a      = sel_r;
        cmd.wr_b      = ~sel_r;
        cmd.take_left = take_left;
        o_nxt         = o_inc;
        if (take_left) begin
          l_nxt   = l_inc;
          rd_addr = l_inc[AW-1:0];
        end else begin
          r_nxt   = r_inc;
          rd_addr = r_inc[AW-1:0];
        end
        if (o_inc == hi_r) begin
          if (hi_r == cnt_r) begin
            // Pass complete: the destination becomes the source of the next pass.
            sel_nxt = ~sel_r;
            w_nxt   = w_dbl;
            lo_nxt  = '0;
            k_nxt   = '0;
            if (w_dbl >= WW'(cnt_r)) begin
              state_nxt = S_ORD;
            end else begin
              state_nxt = S_BLK;
            end
          end else begin
            lo_nxt    = hi_r;
            state_nxt = S_BLK;
          end
        end else if (take_left) begin
          if (l_inc < mid_r) begin
            state_nxt = S_ML;
          end
        end else begin
          if (r_inc < hi_r) begin
            state_nxt = S_MR;
          end
        end
      end
      S_ML: begin
        cmd.ld_l  = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MR: begin
        cmd.ld_r  = 1'b1;
        state_nxt = S_MERGE;
      end
      S_ORD: begin
        rd_addr = k_r[AW-1:0];
        if (!sts.out_busy || out_tready) begin
          state_nxt = S_OLD;
        end
      end
      S_OLD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (k_inc == cnt_r);
        cmd.out_ovf  = drop_r;
        k_nxt        = k_inc;
        if (k_inc == cnt_r) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_ORD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    o_r   <= o_nxt;
    k_r   <= k_nxt;
    sel_r <= sel_nxt;
  end

endmodule

[design/merge_sort_engine_top.sv]
// Top level of the merge sort engine: controller plus datapath.
//
//   channel | direction | payload                                   | handshake
//   in_     | input     | tdata[63:0] value, tlast last             | tvalid/tready
//   out_    | output    | tdata[63:0] sorted_value, tlast end_of_set,| tvalid/tready
//           |           | tuser[0] overflow                         |
//
// Loading accepts one transfer per cycle. The sort runs ceil(log2(N)) merge passes; a pass
// loads both merge heads per block and refills a head after taking from a run with more left,
// as each store has one registered read port. Emitting reads each element, then outputs it.
// Reset (rst_n low, synchronous) empties the set; the stores themselves are not cleared.
// in_tready is high only while a set is being loaded. A stalled output holds the sequencer,
// and the final result of a set may wait in the output register while the next set loads.
module merge_sort_engine_top
  import mse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MSE_MAX_ITEMS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [MSE_DATA_W-1:0] in_tdata,   // [63:0] value
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [MSE_DATA_W-1:0] out_tdata,  // [63:0] sorted_value
  output logic                  out_tlast,
  output logic                  out_tuser   // [0] overflow
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);

  mse_cmd_t      cmd;
  mse_sts_t      sts;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  mse_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  mse_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .sts        (sts),
    .in_value   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[design/mse_chk.sv]
// Port-level checker for the merge sort engine, bound to the top level.
module mse_chk
  import mse_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [MSE_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  logic                  out_xfer;
  logic                  in_close;
  logic [MSE_DATA_W-1:0] prev_r, prev_nxt;
  logic                  have_prev_r, have_prev_nxt;
  logic                  ovf_r, ovf_nxt;

  assign out_xfer = out_tvalid && out_tready;
  assign in_close = in_tvalid && in_tready && in_tlast;

  // Remember the previous result of the current set and its overflow flag to check ordering.
  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    ovf_nxt       = ovf_r;
    if (out_xfer) begin
      prev_nxt      = out_tdata;
      have_prev_nxt = ~out_tlast;
      ovf_nxt       = out_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
    prev_r <= prev_nxt;
    ovf_r  <= ovf_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && have_prev_r |-> $signed(out_tdata) >= $signed(prev_r))
    else $error("results of a set are not in ascending order");

  a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && have_prev_r |-> out_tuser == ovf_r)
    else $error("overflow flag changed within a set");

  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_close |=> !in_tready)
    else $error("input accepted right after the closing transfer");

  a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_tlast |=> !in_tready)
    else $error("input accepted while a set is still being emitted");

endmodule

bind merge_sort_engine_top mse_chk u_mse_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
